// ----- rtl/sha256_stream_hash_core_defines.svh -----
// ============================================================================
// SHA-256 stream hash core: assertion macros
// Shared assertion wrappers; defining ASSERT_OFF removes every check.
// ============================================================================
`ifndef SHA256_STREAM_HASH_CORE_DEFINES_SVH
`define SHA256_STREAM_HASH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/sha_pkg.sv -----
// ============================================================================
// SHA-256 package
// Constants, round functions and the controller/datapath interface types.
// ============================================================================
`default_nettype none

package sha_pkg;

    localparam logic [31:0] SHA_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_START     = 6'd56;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] ROUND_LAST    = 6'd63;
    localparam logic [2:0] WORD_LAST     = 3'd7;

    typedef enum logic [2:0] {
        ST_IN,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } sha_state_t;

    typedef enum logic [1:0] {
        RET_IN,
        RET_MARK,
        RET_ZERO,
        RET_OUT
    } sha_ret_t;

    typedef enum logic [1:0] {
        BSEL_IN,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } sha_bsel_t;

    typedef struct packed {
        logic       shift_en;
        sha_bsel_t  byte_sel;
        logic [2:0] len_idx;
        logic       len_inc;
        logic       work_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       chain_init;
        logic       out_load;
        logic [2:0] out_idx;
    } sha_cmd_t;

    typedef struct packed {
        logic out_free;
    } sha_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sha_datapath.sv -----
// ============================================================================
// SHA-256 datapath
// Block shift register used as message schedule, round registers, chaining
// words, bit-length counter and the output register.
// ============================================================================
`default_nettype none
`include "sha256_stream_hash_core_defines.svh"

module sha_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [7:0]       in_byte,
    input  wire sha_pkg::sha_cmd_t cmd,
    output sha_pkg::sha_stat_t    stat,
    output logic [31:0]           out_word,
    output logic [2:0]            out_num,
    output logic                  out_last,
    output logic                  out_valid,
    input  wire logic             out_ready
);
    import sha_pkg::*;

    logic [511:0] blk_reg, blk_next;
    logic [31:0]  work_reg [0:7];
    logic [31:0]  chain_reg [0:7];
    logic [63:0]  len_reg;
    logic         out_valid_reg;
    logic [31:0]  out_word_reg;
    logic [2:0]   out_num_reg;

    logic [7:0]   byte_mux;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  ch;
    logic [31:0]  maj;

    always_comb begin
        case (cmd.byte_sel)
            BSEL_IN:   byte_mux = in_byte;
            BSEL_MARK: byte_mux = PAD_MARK_BYTE;
            BSEL_ZERO: byte_mux = 8'h00;
            BSEL_LEN:  byte_mux = len_reg[{~cmd.len_idx, 3'b000} +: 8];
            default:   byte_mux = 8'h00;
        endcase
    end

    assign w_cur = blk_reg[511:480];
    assign w_new = ssig1(blk_reg[63:32]) + blk_reg[223:192]
                 + ssig0(blk_reg[479:448]) + blk_reg[511:480];

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + bsig1(work_reg[4]) + ch + SHA_K[cmd.round_idx] + w_cur;
    assign t2  = bsig0(work_reg[0]) + maj;

    always_comb begin
        blk_next = blk_reg;
        if (cmd.shift_en) begin
            blk_next = {blk_reg[503:0], byte_mux};
        end else if (cmd.round_en) begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        if (cmd.work_load) begin
            for (int i = 0; i < 8; i++) begin
                work_reg[i] <= chain_reg[i];
            end
        end else if (cmd.round_en) begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= SHA_IV[i];
            end
            len_reg <= '0;
        end else begin
            if (cmd.chain_init) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= SHA_IV[i];
                end
                len_reg <= '0;
            end else begin
                if (cmd.chain_add) begin
                    for (int i = 0; i < 8; i++) begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.len_inc) begin
                    len_reg <= len_reg + 64'd8;
                end
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_word_reg <= chain_reg[cmd.out_idx];
            out_num_reg  <= cmd.out_idx;
        end
    end

    assign out_word  = out_word_reg;
    assign out_num   = out_num_reg;
    assign out_last  = (out_num_reg == WORD_LAST);
    assign out_valid = out_valid_reg;

    `SHA_ASSERT(a_load_needs_slot, aclk, aresetn, cmd.out_load |-> stat.out_free,
        "Digest word loaded while the output register is still occupied.")
    `SHA_ASSERT(a_shift_xor_round, aclk, aresetn, !(cmd.shift_en && cmd.round_en),
        "Byte shift and schedule shift requested in the same cycle.")

endmodule

`default_nettype wire

// ----- rtl/sha_ctrl.sv -----
// ============================================================================
// SHA-256 controller
// Sequences byte loading, padding, the 64 compression rounds and the
// digest readout.
// ============================================================================
`default_nettype none
`include "sha256_stream_hash_core_defines.svh"

module sha_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic             in_present,
    input  wire logic             in_end,
    output logic                  in_ready,
    output sha_pkg::sha_cmd_t     cmd,
    input  wire sha_pkg::sha_stat_t stat
);
    import sha_pkg::*;

    sha_state_t state_reg, state_next;
    sha_ret_t   ret_reg, ret_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] widx_reg, widx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IN;
            ret_reg   <= RET_IN;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        in_ready   = 1'b0;

        cmd            = '0;
        cmd.byte_sel   = BSEL_IN;
        cmd.len_idx    = fill_reg[2:0];
        cmd.round_idx  = rnd_reg;
        cmd.out_idx    = widx_reg;

        case (state_reg)
            ST_IN: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_present) begin
                        cmd.shift_en = 1'b1;
                        cmd.len_inc  = 1'b1;
                        fill_next    = fill_reg + 6'd1;
                        if (fill_reg == FILL_LAST) begin
                            cmd.work_load = 1'b1;
                            ret_next      = in_end ? RET_MARK : RET_IN;
                            state_next    = ST_COMP;
                        end else if (in_end) begin
                            state_next = ST_PAD_MARK;
                        end
                    end else if (in_end) begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BSEL_MARK;
                fill_next    = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST) begin
                    cmd.work_load = 1'b1;
                    ret_next      = RET_ZERO;
                    state_next    = ST_COMP;
                end else begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (fill_reg == LEN_START) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_sel = BSEL_ZERO;
                    fill_next    = fill_reg + 6'd1;
                    if (fill_reg == FILL_LAST) begin
                        cmd.work_load = 1'b1;
                        ret_next      = RET_ZERO;
                        state_next    = ST_COMP;
                    end
                end
            end
            ST_PAD_LEN: begin
                cmd.shift_en = 1'b1;
                cmd.byte_sel = BSEL_LEN;
                fill_next    = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST) begin
                    cmd.work_load = 1'b1;
                    ret_next      = RET_OUT;
                    state_next    = ST_COMP;
                end
            end
            ST_COMP: begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                case (ret_reg)
                    RET_IN:   state_next = ST_IN;
                    RET_MARK: state_next = ST_PAD_MARK;
                    RET_ZERO: state_next = ST_PAD_ZERO;
                    RET_OUT:  state_next = ST_OUT;
                    default:  state_next = ST_IN;
                endcase
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    widx_next    = widx_reg + 3'd1;
                    if (widx_reg == WORD_LAST) begin
                        cmd.chain_init = 1'b1;
                        state_next     = ST_IN;
                    end
                end
            end
            default: begin
                state_next = ST_IN;
            end
        endcase
    end

    `SHA_ASSERT(a_out_fill_empty, aclk, aresetn, (state_reg == ST_OUT) |-> (fill_reg == 6'd0),
        "Digest readout started with a partly filled block.")
    `SHA_ASSERT(a_round_idle_zero, aclk, aresetn,
        (state_reg != ST_COMP) |-> (rnd_reg == 6'd0),
        "Round counter left nonzero outside compression.")
    `SHA_ASSERT(a_final_to_out, aclk, aresetn,
        (state_reg == ST_ADD && ret_reg == RET_OUT) |=> (state_reg == ST_OUT),
        "Final block did not lead to digest readout.")
    `SHA_ASSERT(a_len_after_zero, aclk, aresetn,
        (state_reg == ST_PAD_LEN) |-> (fill_reg >= LEN_START),
        "Length bytes placed before byte 56 of the block.")

endmodule

`default_nettype wire

// ----- rtl/sha256_stream_hash_core.sv -----
// ============================================================================
// SHA-256 stream hash core
// Byte-serial SHA-256 engine with a streaming input and a word output.
// ============================================================================
// Usage: each input transfer carries one byte on s_tdata, a byte-present flag
// on s_tuser and an end-of-message flag on s_tlast. A transfer with neither
// flag set changes nothing; end without a byte closes the message as it is.
// Bytes are shifted one per cycle, while s_tready is high, into a 512-bit
// block register. Each full block is then compressed in 64 rounds of a
// single round unit and folded into the chaining words with s_tready low.
// At the end of a message the controller shifts in padding and the bit
// length one byte per cycle, with an idle step in ST_PAD_ZERO before the
// length. When the length spills into an extra block, the mark and zero
// bytes close the current block, which is compressed, and zero bytes, the
// idle step and the length fill the extra one. The last block is compressed
// and the digest is emitted as eight 32-bit transfers on m_tdata, word
// number on m_tuser, m_tlast on the eighth word.
// A stalled receiver holds the current word in the output register and the
// engine waits; input is taken again once the eighth word is loaded.
// ============================================================================
`default_nettype none

module sha256_stream_hash_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
    input  wire logic [0:0]  s_tuser,    // [0] byte_present
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] digest_word
    output logic [2:0]       m_tuser,    // [2:0] word_number
    output logic             m_tlast
);
    import sha_pkg::*;

    sha_cmd_t  cmd;
    sha_stat_t stat;

    sha_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_present (s_tuser[0]),
        .in_end     (s_tlast),
        .in_ready   (s_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    sha_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (m_tdata),
        .out_num   (m_tuser),
        .out_last  (m_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready)
    );

endmodule

`default_nettype wire

// ----- tb/sha256_stream_hash_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// SHA-256 stream hash core testbench
// Feeds byte transfers into the core and checks every digest word against a
// behavioral SHA-256 model. A short directed table covers empty messages,
// ignored transfers, byte-with-end and known digests; random messages follow,
// with lengths around the padding and block boundaries, under several
// patterns of sender gaps and receiver stalls.
// ============================================================================

module sha256_stream_hash_core_tb;

    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE_CYCLES = 300;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         closes;
        logic         known;
        logic [255:0] digest;
    } byte_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam int DIRECTED_ROWS = 17;

    // A typed digest is used only for the empty message and "abc".
    localparam byte_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hff, 1'b0, 1'b0, 1'b0, 256'd0},
        '{8'h61, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 256'd0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h00, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h7f, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'haa, 1'b0, 1'b0, 1'b0, 256'd0},
        '{8'h55, 1'b1, 1'b1, 1'b0, 256'd0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 256'd0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 256'd0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 256'd0},
        '{8'h5a, 1'b0, 1'b1, 1'b0, 256'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int fail_count = 0;

    logic [31:0] hash_state [8];
    logic [7:0]  block_buf [64];
    int          block_fill;
    logic [63:0] msg_bits;

    digest_word_t pending_digest [$];

    sha256_stream_hash_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, wr, t1, t2;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {block_buf[4 * i], block_buf[4 * i + 1],
                    block_buf[4 * i + 2], block_buf[4 * i + 3]};
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (i = 0; i < 64; i++) begin
            if (i < 16) begin
                wr = w[i];
            end else begin
                s0 = ror(w[(i - 15) & 15], 7) ^ ror(w[(i - 15) & 15], 18)
                     ^ (w[(i - 15) & 15] >> 3);
                s1 = ror(w[(i - 2) & 15], 17) ^ ror(w[(i - 2) & 15], 19)
                     ^ (w[(i - 2) & 15] >> 10);
                wr = w[i & 15] + s0 + w[(i - 7) & 15] + s1;
                w[i & 15] = wr;
            end
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + wr;
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic sha_restart();
        hash_state = INIT_HASH;
        block_fill = 0;
        msg_bits = '0;
    endtask

    // Absorbs one accepted transfer; on end of message pads, finishes the
    // digest and starts the next message from the initial hash values.
    task automatic sha_absorb(input logic [7:0] data, input logic present,
                              input logic closes, output logic closed,
                              output logic [255:0] digest);
        int i;
        closed = 1'b0;
        digest = '0;
        if (present) begin
            block_buf[block_fill] = data;
            msg_bits += 64'd8;
            block_fill++;
            if (block_fill == 64) begin
                sha_compress();
                block_fill = 0;
            end
        end
        if (closes) begin
            block_buf[block_fill] = 8'h80;
            for (i = block_fill + 1; i < 64; i++) block_buf[i] = 8'h00;
            if (block_fill + 1 > 56) begin
                sha_compress();
                for (i = 0; i < 64; i++) block_buf[i] = 8'h00;
            end
            for (i = 0; i < 8; i++) block_buf[63 - i] = msg_bits[8 * i +: 8];
            sha_compress();
            for (i = 0; i < 8; i++) digest[255 - 32 * i -: 32] = hash_state[i];
            closed = 1'b1;
            sha_restart();
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input logic [7:0] data, input logic present,
                             input logic closes, input logic known,
                             input logic [255:0] known_digest);
        logic closed;
        logic [255:0] digest;
        digest_word_t entry;
        int i;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= present;
        s_tlast <= closes;
        do @(posedge aclk); while (!s_tready);
        sha_absorb(data, present, closes, closed, digest);
        if (closed) begin
            if (known) digest = known_digest;
            for (i = 0; i < 8; i++) begin
                entry.word = digest[255 - 32 * i -: 32];
                entry.index = i[2:0];
                entry.last = (i == 7);
                pending_digest.push_back(entry);
            end
        end
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        digest_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digest.size() == 0) begin
                note_failure($sformatf("unexpected transfer: word %08h index %0d last %0b",
                                       m_tdata, m_tuser, m_tlast));
            end else begin
                want = pending_digest.pop_front();
                if (m_tdata !== want.word || m_tuser !== want.index
                        || m_tlast !== want.last) begin
                    note_failure($sformatf(
                        "digest mismatch: expected %08h/%0d/%0b, got %08h/%0d/%0b",
                        want.word, want.index, want.last, m_tdata, m_tuser, m_tlast));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int random_items;
        int msg_len;
        int n;
        logic joined;
        random_items = 0;
        sha_restart();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            send_byte(DIRECTED[n].data, DIRECTED[n].present, DIRECTED[n].closes,
                      DIRECTED[n].known, DIRECTED[n].digest);
        end

        while (random_items < RANDOM_ITEMS) begin
            case (random_items * 4 / RANDOM_ITEMS)
                0: begin send_idle_pct = 0; ready_stall_pct = 0; end
                1: begin send_idle_pct = 65; ready_stall_pct = 0; end
                2: begin send_idle_pct = 0; ready_stall_pct = 65; end
                default: begin send_idle_pct = 7; ready_stall_pct = 7; end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: msg_len = $urandom_range(0, 8);
                5, 6, 7: begin
                    case ($urandom_range(0, 7))
                        0: msg_len = 55;
                        1: msg_len = 56;
                        2: msg_len = 57;
                        3: msg_len = 63;
                        4: msg_len = 64;
                        5: msg_len = 65;
                        6: msg_len = 119;
                        default: msg_len = 120;
                    endcase
                end
                8: msg_len = $urandom_range(9, 60);
                default: msg_len = $urandom_range(100, 130);
            endcase
            joined = (msg_len > 0) && ($urandom_range(0, 1) == 1);
            for (n = 0; n < msg_len; n++) begin
                if ($urandom_range(0, 15) == 0) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                    random_items++;
                end
                send_byte(8'($urandom_range(0, 255)), 1'b1, joined && (n == msg_len - 1),
                          1'b0, '0);
                random_items++;
            end
            if (!joined) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
                random_items++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_digest.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_digest.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hash_core.sv
tb/sha256_stream_hash_core_tb.sv
